### sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned WGT_W  = 32;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned HDL_W  = 9;
  localparam int unsigned STAT_W = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic [SYM_W-1:0] symbol;
    logic [HDL_W-1:0] handle;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_ERR_EMPTY,
    OP_ERR_FULL
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic load_out;
    op_e  op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind;
    logic empty;
    logic full;
  } stat_t;

  typedef struct packed {
    logic [HDL_W-1:0]  handle;
    logic [WGT_W-1:0]  weight;
    logic [SYM_W-1:0]  symbol;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic              size_is_one;
  } result_t;

  // strict order: weight first, then symbol
  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.weight != b.weight) begin
      r = a.weight < b.weight;
    end else begin
      r = a.symbol < b.symbol;
    end
    return r;
  endfunction

endpackage

### sv/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  op_e    op_sel;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    if (stat_i.kind == KIND_ENQ) begin
      op_sel = stat_i.full ? OP_ERR_FULL : OP_INSERT;
    end else begin
      op_sel = stat_i.empty ? OP_ERR_EMPTY : OP_REMOVE;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.op       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.op       = op_sel;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/spq_datapath.sv
module spq_datapath import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    kind_i,
  input  entry_t  entry_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output result_t result_o
);

  logic              kind_q;
  entry_t            new_q;
  entry_t            cells_q [DEPTH];
  entry_t            cells_d [DEPTH];
  logic [DEPTH-1:0]  lt;
  logic [OCC_W-1:0]  occ_q, occ_d;
  result_t           res_q, res_d;

  assign stat_o.kind  = kind_q;
  assign stat_o.empty = (occ_q == '0);
  assign stat_o.full  = (occ_q == OCC_W'(DEPTH));
  assign result_o     = res_q;

  // each cell compares the new entry with its own content; empty cells count as larger
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (OCC_W'(i) < occ_q) ? entry_before(new_q, cells_q[i]) : 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_d[i] = cells_q[i];
    end
    case (cmd_i.op)
      OP_INSERT: begin
        if (lt[0]) begin
          cells_d[0] = new_q;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (lt[i]) begin
            cells_d[i] = lt[i-1] ? cells_q[i-1] : new_q;
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          cells_d[i] = cells_q[i+1];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    res_d = '0;
    case (cmd_i.op)
      OP_INSERT: begin
        occ_d = occ_q + OCC_W'(1);
      end
      OP_REMOVE: begin
        occ_d        = occ_q - OCC_W'(1);
        res_d.handle = cells_q[0].handle;
        res_d.weight = cells_q[0].weight;
        res_d.symbol = cells_q[0].symbol;
      end
      OP_ERR_EMPTY: res_d.status = STATUS_EMPTY;
      OP_ERR_FULL:  res_d.status = STATUS_FULL;
      default: ;
    endcase
    res_d.is_empty    = (occ_d == '0);
    res_d.size_is_one = (occ_d == OCC_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.load_out) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= kind_i;
      new_q  <= entry_i;
    end
    if (cmd_i.load_out) begin
      res_q <= res_d;
    end
    if (cmd_i.op == OP_INSERT || cmd_i.op == OP_REMOVE) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

endmodule

### sv/sorted_priority_queue_core.sv
// result: registered into the output register from the execute state that follows the capture, one result per item
// flow: one item in flight (capture state, then one parallel compare-and-shift step over the
//   row of cells); the execute state waits while the output register is stalled
// reset: rst_ni asynchronous active low, clears controller state, output valid and occupancy;
//   cell contents are not reset and are only read below the occupancy
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // weight[31:0], symbol[39:32], node_handle[48:40], zero pad
  input  logic [0:0]  s_axis_tuser_i,   // kind[0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // out_handle[8:0], out_weight[40:9], out_symbol[48:41],
                                        // is_empty[49], size_is_one[50], zero pad
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  entry_t  in_entry;

  // unpack the incoming transaction payload
  assign in_entry.weight = s_axis_tdata_i[31:0];
  assign in_entry.symbol = s_axis_tdata_i[39:32];
  assign in_entry.handle = s_axis_tdata_i[48:40];

  // sequencer: capture, execute, hand result to the output register
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // sorted row of cells, occupancy and result register
  spq_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kind_i   (s_axis_tuser_i[0]),
    .entry_i  (in_entry),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (res)
  );

  // pack the result transaction
  assign m_axis_tdata_o = {5'b0, res.size_is_one, res.is_empty,
                           res.symbol, res.weight, res.handle};
  assign m_axis_tuser_o = res.status;

endmodule

### sv/spq_checker.sv
module spq_checker import spq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [55:0] s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // one item in flight: no new input right after an accepted one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // empty dequeue gives zero entry and an empty queue
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_EMPTY |->
      m_axis_tdata_o[48:0] == '0 && m_axis_tdata_o[49] && !m_axis_tdata_o[50])
    else $error("bad empty dequeue result");

  // full overflow leaves the queue neither empty nor single, no entry data
  a_err_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_FULL |->
      m_axis_tdata_o[48:0] == '0 && !m_axis_tdata_o[49] && !m_axis_tdata_o[50])
    else $error("bad overflow result");

  // flags never both set, status never out of range
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[49] && m_axis_tdata_o[50]) && m_axis_tuser_o != 2'd3)
    else $error("inconsistent result flags");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
